/* rtl/periodic_task_timer_table_unit_macros.svh */
// Assertion macros shared by the timer table RTL.
`ifndef PERIODIC_TASK_TIMER_TABLE_UNIT_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ptt_pkg.sv */
// Types and constants of the periodic timer table.
package ptt_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int REM_W      = 34;
  localparam int STEP_W     = 10;
  localparam int CFG_AW     = 2;

  // Command codes
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_CANCEL = 3'd1;
  localparam logic [2:0] OP_PAUSE  = 3'd2;
  localparam logic [2:0] OP_RESUME = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRED  = 1'b1;

  // Register map (byte addresses)
  localparam logic [CFG_AW-1:0] ADDR_TICK_STEP = 2'd0;
  localparam logic [STEP_W-1:0] TICK_STEP_RESET = 10'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] target_id;
    logic [31:0] period_ms;
    logic        repeating;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] result_id;
    logic        ok;
    logic        last;
  } out_item_t;

endpackage

/* rtl/periodic_task_timer_table_unit.sv */
// Periodic timer table: slot scan sequencer, slot storage and APB register.
//
//  channel   ports                                      direction  handshake
//  command   start, busy, in_item                       in         start & !busy
//  result    out_valid, out_item                        out        one-cycle strobe
//  config    cfg_psel/penable/pwrite/paddr/pwdata/...   in/out     APB, pready tied high
//
// Every command scans each slot in turn through the shared subtract/compare unit,
// then passes through the finish state, after which busy drops.
// A status result shows in the cycle after finish. A fired result waits until the
// next firing slot is found, so the final fired result also shows after finish.
// Reset (rst_n low, synchronous) clears the valid bits, next id and sequencer;
// tick step returns to 10. Results cannot be stalled by the receiver.
`include "periodic_task_timer_table_unit_macros.svh"

module periodic_task_timer_table_unit
  import ptt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  // result channel
  output logic              out_valid,
  output out_item_t         out_item,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // slot storage
  logic [NUM_SLOTS-1:0]    slot_valid_r;
  logic [31:0]             slot_id_r     [NUM_SLOTS];
  logic [31:0]             slot_period_r [NUM_SLOTS];
  logic signed [REM_W-1:0] slot_rem_r    [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]    slot_repeat_r;
  logic [NUM_SLOTS-1:0]    slot_paused_r;

  // control and command registers
  state_t                  state_r, state_nxt;
  logic [SLOT_IDX_W-1:0]   idx_r, idx_nxt;
  in_item_t                cmd_r;
  logic                    found_r, found_nxt;
  logic                    ok_r, ok_nxt;
  logic                    pend_v_r, pend_v_nxt;
  logic [31:0]             pend_id_r, pend_id_nxt;
  logic [31:0]             next_id_r, next_id_nxt;
  logic [STEP_W-1:0]       step_r;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;

  // slot write controls
  logic                    add_en, clr_valid, set_pause, clr_pause, rem_en;
  logic signed [REM_W-1:0] rem_wdata;

  // current slot view and shared subtract unit
  logic                    cur_valid, cur_paused, cur_repeat, id_match;
  logic signed [REM_W-1:0] rem_sub;
  logic                    fire;
  logic                    accept, cfg_wr, last_slot;

  assign accept    = start && (state_r == ST_IDLE);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign last_slot = (idx_r == SLOT_IDX_W'(NUM_SLOTS - 1));

  assign cur_valid  = slot_valid_r[idx_r];
  assign cur_paused = slot_paused_r[idx_r];
  assign cur_repeat = slot_repeat_r[idx_r];
  assign id_match   = cur_valid && (slot_id_r[idx_r] == cmd_r.target_id);
  assign rem_sub    = slot_rem_r[idx_r] - $signed({{(REM_W-STEP_W){1'b0}}, step_r});
  assign fire       = rem_sub[REM_W-1] || (rem_sub == '0);

  // sequencer: next state, slot updates and result selection
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    ok_nxt        = ok_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    next_id_nxt   = next_id_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    add_en        = 1'b0;
    clr_valid     = 1'b0;
    set_pause     = 1'b0;
    clr_pause     = 1'b0;
    rem_en        = 1'b0;
    rem_wdata     = rem_sub;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt  = ST_SCAN;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          ok_nxt     = 1'b0;
          pend_v_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        unique case (cmd_r.op)
          OP_ADD: begin
            // lowest free slot takes the new timer
            if (!found_r && !cur_valid) begin
              add_en    = 1'b1;
              found_nxt = 1'b1;
              ok_nxt    = 1'b1;
            end
          end
          OP_CANCEL: begin
            if (!found_r && id_match) begin
              clr_valid = 1'b1;
              found_nxt = 1'b1;
              ok_nxt    = 1'b1;
            end
          end
          OP_PAUSE: begin
            if (!found_r && id_match) begin
              found_nxt = 1'b1;
              ok_nxt    = !cur_paused;
              set_pause = !cur_paused;
            end
          end
          OP_RESUME: begin
            if (!found_r && id_match) begin
              found_nxt = 1'b1;
              ok_nxt    = cur_paused;
              clr_pause = cur_paused;
            end
          end
          OP_TICK: begin
            if (cur_valid && !cur_paused) begin
              rem_en = 1'b1;
              if (fire) begin
                // previous fire is known not to be the final one
                if (pend_v_r) begin
                  out_valid_nxt = 1'b1;
                  out_item_nxt  = '{kind: KIND_FIRED, result_id: pend_id_r,
                                    ok: 1'b1, last: 1'b0};
                end
                pend_v_nxt  = 1'b1;
                pend_id_nxt = slot_id_r[idx_r];
                rem_wdata   = $signed({{(REM_W-32){1'b0}}, slot_period_r[idx_r]});
                clr_valid   = !cur_repeat;
              end
            end
          end
          default: ;
        endcase
        idx_nxt = idx_r + 1'b1;
        if (last_slot) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
        if (cmd_r.op == OP_TICK) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{kind: KIND_FIRED, result_id: pend_id_r,
                              ok: 1'b1, last: 1'b1};
          end
          pend_v_nxt = 1'b0;
        end else begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_STATUS, result_id: '0, ok: ok_r, last: 1'b1};
          unique case (cmd_r.op)
            OP_ADD: begin
              if (ok_r) begin
                out_item_nxt.result_id = next_id_r;
                next_id_nxt            = next_id_r + 32'd1;
              end
            end
            OP_CANCEL, OP_PAUSE, OP_RESUME: begin
              out_item_nxt.result_id = cmd_r.target_id;
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      ok_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
      step_r      <= TICK_STEP_RESET;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      ok_r        <= ok_nxt;
      pend_v_r    <= pend_v_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && (cfg_paddr == ADDR_TICK_STEP)) begin
        step_r <= cfg_pwdata[STEP_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item;
    end
    pend_id_r  <= pend_id_nxt;
    out_item_r <= out_item_nxt;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (add_en) begin
      slot_valid_r[idx_r] <= 1'b1;
    end else if (clr_valid) begin
      slot_valid_r[idx_r] <= 1'b0;
    end
  end

  // slot fields, one slot written per cycle
  always_ff @(posedge clk) begin
    if (add_en) begin
      slot_id_r[idx_r]     <= next_id_r;
      slot_period_r[idx_r] <= cmd_r.period_ms;
      slot_rem_r[idx_r]    <= $signed({{(REM_W-32){1'b0}}, cmd_r.period_ms});
      slot_repeat_r[idx_r] <= cmd_r.repeating;
      slot_paused_r[idx_r] <= 1'b0;
    end else begin
      if (rem_en) begin
        slot_rem_r[idx_r] <= rem_wdata;
      end
      if (set_pause) begin
        slot_paused_r[idx_r] <= 1'b1;
      end else if (clr_pause) begin
        slot_paused_r[idx_r] <= 1'b0;
      end
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_TICK_STEP) ? {{(32-STEP_W){1'b0}}, step_r} : '0;

  // checks
  `PTT_ASSERT_NOW(a_status_is_last, out_valid_r && (out_item_r.kind == KIND_STATUS),
                  out_item_r.last, "status result without last")
  `PTT_ASSERT_NOW(a_fired_ok, out_valid_r && (out_item_r.kind == KIND_FIRED),
                  out_item_r.ok, "fired result without ok")
  `PTT_ASSERT_NEXT(a_accept_starts_scan, accept, (state_r == ST_SCAN) && (idx_r == '0),
                   "scan did not start at slot zero")
  `PTT_ASSERT_NEXT(a_finish_to_idle, state_r == ST_FINISH, (state_r == ST_IDLE) && !pend_v_r,
                   "finish did not drain")
  `PTT_ASSERT_NOW(a_single_slot_op, add_en, !clr_valid && !rem_en,
                  "conflicting slot writes")

endmodule

/* bench/timer_table_checker.sv */
// Checker for the timer table: tracks commands and config writes, predicts and compares.
`timescale 1ns / 1ps

module timer_table_checker
  import ptt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  in_item_t          in_item,
  input  logic              out_valid,
  input  out_item_t         out_item,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic [31:0]       cfg_prdata,
  input  logic              cfg_pready,
  output int                mismatches,
  output int                results_outstanding,
  output int                status_seen,
  output int                fired_seen
);

  // Shadow copy of the timer slots
  logic                    slot_armed  [NUM_SLOTS];
  logic [31:0]             slot_id     [NUM_SLOTS];
  logic [31:0]             slot_period [NUM_SLOTS];
  logic signed [REM_W-1:0] slot_left   [NUM_SLOTS];
  logic                    slot_reload [NUM_SLOTS];
  logic                    slot_held   [NUM_SLOTS];
  logic [31:0]             next_timer_id;
  logic [STEP_W-1:0]       tick_step;

  out_item_t awaited_results[$];

  int fail_count   = 0;
  int status_count = 0;
  int fired_count  = 0;
  int awaited_now  = 0;

  assign mismatches          = fail_count;
  assign results_outstanding = awaited_now;
  assign status_seen         = status_count;
  assign fired_seen          = fired_count;

  // Lowest armed slot holding this id, -1 if none
  function automatic int slot_of_id(input logic [31:0] id);
    int i;
    for (i = 0; i < NUM_SLOTS; i++)
      if (slot_armed[i] && slot_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void clear_slots();
    int i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      slot_armed[i]  = 1'b0;
      slot_id[i]     = '0;
      slot_period[i] = '0;
      slot_left[i]   = '0;
      slot_reload[i] = 1'b0;
      slot_held[i]   = 1'b0;
    end
    next_timer_id = '0;
    tick_step     = TICK_STEP_RESET;
  endfunction

  // Append one expected result at the tail of the queue
  function automatic void expect_item(input out_item_t r);
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  // Apply one command to the shadow slots and queue the results it causes
  function automatic void predict_results(input in_item_t cmd);
    out_item_t   r;
    logic [31:0] fired_ids[$];
    int          s;
    int          i;
    r.kind      = KIND_STATUS;
    r.result_id = '0;
    r.ok        = 1'b0;
    r.last      = 1'b1;
    case (cmd.op)
      OP_ADD: begin
        s = -1;
        for (i = NUM_SLOTS - 1; i >= 0; i--)
          if (!slot_armed[i]) s = i;
        if (s >= 0) begin
          slot_armed[s]  = 1'b1;
          slot_id[s]     = next_timer_id;
          slot_period[s] = cmd.period_ms;
          slot_left[s]   = $signed({2'b00, cmd.period_ms});
          slot_reload[s] = cmd.repeating;
          slot_held[s]   = 1'b0;
          r.result_id    = next_timer_id;
          r.ok           = 1'b1;
          next_timer_id  = next_timer_id + 32'd1;
        end
        expect_item(r);
      end
      OP_CANCEL: begin
        s = slot_of_id(cmd.target_id);
        r.result_id = cmd.target_id;
        if (s >= 0) begin
          slot_armed[s] = 1'b0;
          r.ok          = 1'b1;
        end
        expect_item(r);
      end
      OP_PAUSE: begin
        s = slot_of_id(cmd.target_id);
        r.result_id = cmd.target_id;
        if (s >= 0 && !slot_held[s]) begin
          slot_held[s] = 1'b1;
          r.ok         = 1'b1;
        end
        expect_item(r);
      end
      OP_RESUME: begin
        s = slot_of_id(cmd.target_id);
        r.result_id = cmd.target_id;
        if (s >= 0 && slot_held[s]) begin
          slot_held[s] = 1'b0;
          r.ok         = 1'b1;
        end
        expect_item(r);
      end
      OP_TICK: begin
        // Max results equals the slot count, so every fire is reported
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (slot_armed[i] && !slot_held[i]) begin
            slot_left[i] = slot_left[i] - $signed({{(REM_W - STEP_W){1'b0}}, tick_step});
            if (slot_left[i] <= 0) begin
              fired_ids.insert(fired_ids.size(), slot_id[i]);
              if (slot_reload[i]) slot_left[i] = $signed({2'b00, slot_period[i]});
              else slot_armed[i] = 1'b0;
            end
          end
        end
        for (i = 0; i < fired_ids.size(); i++) begin
          r.kind      = KIND_FIRED;
          r.result_id = fired_ids[i];
          r.ok        = 1'b1;
          r.last      = (i == fired_ids.size() - 1);
          expect_item(r);
        end
      end
      // unknown op: failed status, nothing changes
      default: expect_item(r);
    endcase
  endfunction

  function automatic void flag_field(input string field, input logic [31:0] want,
                                     input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    fail_count++;
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (got.kind === KIND_FIRED) fired_count++;
    else status_count++;
    if (awaited_results.size() == 0) begin
      $display("%0t: result with none pending, expected nothing, %s %0d id %0h ok %0d last %0d",
               $time, "got kind", got.kind, got.result_id, got.ok, got.last);
      fail_count++;
    end else begin
      want = awaited_results.pop_front();
      if (got.kind !== want.kind) flag_field("kind", 32'(want.kind), 32'(got.kind));
      if (got.result_id !== want.result_id) flag_field("result_id", want.result_id, got.result_id);
      if (got.ok !== want.ok) flag_field("ok", 32'(want.ok), 32'(got.ok));
      if (got.last !== want.last) flag_field("last", 32'(want.last), 32'(got.last));
    end
  endfunction

  // Results are compared before a new command's results are queued
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_slots();
      awaited_results.delete();
    end else begin
      if (out_valid) check_result(out_item);
      if (start && !busy) predict_results(in_item);
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == ADDR_TICK_STEP) begin
        if (cfg_pwrite) begin
          tick_step = cfg_pwdata[STEP_W-1:0];
        end else if (cfg_prdata !== {{(32 - STEP_W){1'b0}}, tick_step}) begin
          flag_field("tick step readback", {{(32 - STEP_W){1'b0}}, tick_step}, cfg_prdata);
        end
      end
    end
    awaited_now <= awaited_results.size();
  end

endmodule

/* bench/periodic_task_timer_table_unit_tb.sv */
// Testbench top for the timer table: clock, reset, command and register stimulus, verdict.
`timescale 1ns / 1ps

module periodic_task_timer_table_unit_tb;
  import ptt_pkg::*;

  // Op codes the block does not define
  localparam logic [2:0] OP_UNDEFINED_LO = 3'd5;
  localparam logic [2:0] OP_UNDEFINED_HI = 3'd7;

  localparam int PHASE_ITEMS  = 50;
  localparam int DRAIN_CYCLES = NUM_SLOTS + 8;
  localparam int CYCLE_LIMIT  = 150000;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  in_item_t          in_item     = '0;
  logic              out_valid;
  out_item_t         out_item;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int mismatches;
  int results_outstanding;
  int status_seen;
  int fired_seen;

  int unsigned step_now     = 32'(TICK_STEP_RESET);
  int unsigned step_plan[5];
  logic [31:0] ids_handed   = '0;
  int          burst_left   = 0;
  int          items_sent   = 0;
  int          settings_run = 1;
  int          cycle_count  = 0;

  periodic_task_timer_table_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  timer_table_checker u_timer_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_item            (in_item),
    .out_valid          (out_valid),
    .out_item           (out_item),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready),
    .mismatches         (mismatches),
    .results_outstanding(results_outstanding),
    .status_seen        (status_seen),
    .fired_seen         (fired_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, results_outstanding);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_item_t make_cmd(input logic [2:0] op, input logic [31:0] target,
                                        input logic [31:0] period, input logic rep);
    in_item_t c;
    c.op        = op;
    c.target_id = target;
    c.period_ms = period;
    c.repeating = rep;
    return c;
  endfunction

  // Idle cycles before the next item; bursts of back-to-back items now and then
  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Mostly plausible commands: recent ids as targets, periods a few ticks long
  function automatic in_item_t random_command();
    in_item_t    c;
    int unsigned pick;
    int unsigned back;
    pick = $urandom_range(0, 99);
    c = make_cmd(OP_TICK, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
    if (pick < 30) c.op = OP_ADD;
    else if (pick < 42) c.op = OP_CANCEL;
    else if (pick < 54) c.op = OP_PAUSE;
    else if (pick < 66) c.op = OP_RESUME;
    else if (pick < 96) c.op = OP_TICK;
    else c.op = 3'($urandom_range(OP_UNDEFINED_LO, OP_UNDEFINED_HI));
    if ($urandom_range(0, 9) != 0) c.period_ms = $urandom_range(0, 4 * step_now + 4);
    if (ids_handed != 0 && $urandom_range(0, 4) != 0) begin
      back = (ids_handed < 20) ? ids_handed : 20;
      c.target_id = ids_handed - $urandom_range(1, back);
    end
    return c;
  endfunction

  // Hold start with the item until the block takes it
  task automatic send_command(input in_item_t cmd);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (cmd.op == OP_ADD) ids_handed++;
  endtask

  // Stop sending until every result is in and the block has gone idle
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // APB write of the tick step, then a read back in the following transfer
  task automatic write_tick_step(input int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_TICK_STEP;
    cfg_pwdata  <= {{(32 - STEP_W){1'b0}}, value[STEP_W-1:0]};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    step_now = value;
    settings_run++;
  endtask

  task automatic run_directed();
    send_command(make_cmd(OP_UNDEFINED_HI, '1, '1, 1'b1));  // unknown op
    send_command(make_cmd(OP_TICK, '0, '0, 1'b0));          // empty table, no result
    send_command(make_cmd(OP_ADD, '1, '0, 1'b0));           // id 0: zero period one-shot
    send_command(make_cmd(OP_ADD, '0, '1, 1'b1));           // id 1: longest period
    send_command(make_cmd(OP_ADD, '0, 32'd10, 1'b1));       // id 2: hits zero exactly
    send_command(make_cmd(OP_PAUSE, 32'd1, '0, 1'b0));
    send_command(make_cmd(OP_PAUSE, 32'd1, '0, 1'b0));      // already paused
    send_command(make_cmd(OP_RESUME, 32'd2, '0, 1'b0));     // not paused
    send_command(make_cmd(OP_RESUME, 32'd1, '0, 1'b0));
    send_command(make_cmd(OP_CANCEL, '1, '0, 1'b0));        // unknown id
    send_command(make_cmd(OP_TICK, '0, '0, 1'b0));          // ids 0 and 2 fire
    // fill every slot; the last add finds the table full
    repeat (15) send_command(make_cmd(OP_ADD, $urandom(), $urandom_range(0, 40),
                                      1'($urandom_range(0, 1))));
  endtask

  task automatic run_random(input int count);
    repeat (count) begin
      send_command(random_command());
      if ($urandom_range(0, 39) == 0) wait_for_drain();
    end
  endtask

  initial begin
    step_plan    = '{1, 1000, 0, 1023, 0};
    step_plan[4] = $urandom_range(2, 999);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(PHASE_ITEMS);
    foreach (step_plan[k]) begin
      wait_for_drain();
      write_tick_step(step_plan[k]);
      run_random(PHASE_ITEMS);
    end
    wait_for_drain();

    $display("%0d commands under %0d tick step settings (1, 1000, 0, 1023 among them)",
             items_sent, settings_run);
    $display("%0d status and %0d fired results checked, %0d mismatches",
             status_seen, fired_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
